@@ hw/rtl/fhfa_pkg.sv @@
// Shared types, field widths and codes for the face heat flux accumulator.
// No dependencies; every other file of the block imports this package.
package fhfa_pkg;

  // Default sizing of the accumulator store.
  localparam int CELL_COUNT_DEF = 4096;
  localparam int ACC_WIDTH_DEF  = 48;

  // Field widths of the input and result beats.
  localparam int KIND_W   = 2;
  localparam int CELL_W   = 12;
  localparam int VEC_W    = 63;
  localparam int COMP_W   = 21;
  localparam int SCALAR_W = 32;
  localparam int HEAT_W   = 48;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_INTERIOR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WALL     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OTHER    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ     = 2'd3;

  // One face or read request as captured at the input.
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [CELL_W-1:0]   cell_a;
    logic [CELL_W-1:0]   cell_b;
    logic [VEC_W-1:0]    normal_packed;
    logic [SCALAR_W-1:0] face_area;
    logic [VEC_W-1:0]    grad_a_packed;
    logic [VEC_W-1:0]    grad_b_packed;
    logic [SCALAR_W-1:0] cond_a;
    logic [SCALAR_W-1:0] cond_b;
    logic [SCALAR_W-1:0] vol_a;
    logic [SCALAR_W-1:0] vol_b;
  } item_t;

  // Status of the flux datapath toward the controller.
  typedef struct packed {
    logic done;
    logic skip;
  } flux_stat_t;

  // Access strobes toward the accumulator memory.
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

  // Pick one 21-bit component out of a packed x,y,z vector.
  function automatic logic signed [COMP_W-1:0] pick_comp(input logic [VEC_W-1:0] vec,
                                                          input logic [1:0] idx);
    logic signed [COMP_W-1:0] res;
    case (idx)
      2'd0:    res = vec[20:0];
      2'd1:    res = vec[41:21];
      default: res = vec[62:42];
    endcase
    return res;
  endfunction

endpackage

@@ hw/rtl/fhfa_in_if.sv @@
// Input channel of the face heat flux accumulator: valid/ready and one item.
// Depends on fhfa_pkg for the field widths.
interface fhfa_in_if import fhfa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [CELL_W-1:0]   cell_a;
  logic [CELL_W-1:0]   cell_b;
  logic [VEC_W-1:0]    normal_packed;
  logic [SCALAR_W-1:0] face_area;
  logic [VEC_W-1:0]    grad_a_packed;
  logic [VEC_W-1:0]    grad_b_packed;
  logic [SCALAR_W-1:0] cond_a;
  logic [SCALAR_W-1:0] cond_b;
  logic [SCALAR_W-1:0] vol_a;
  logic [SCALAR_W-1:0] vol_b;

  modport source(output valid, kind, cell_a, cell_b, normal_packed, face_area,
                 grad_a_packed, grad_b_packed, cond_a, cond_b, vol_a, vol_b,
                 input ready);
  modport sink(input valid, kind, cell_a, cell_b, normal_packed, face_area,
               grad_a_packed, grad_b_packed, cond_a, cond_b, vol_a, vol_b,
               output ready);
endinterface

@@ hw/rtl/fhfa_out_if.sv @@
// Result channel of the face heat flux accumulator: valid/ready and one result.
// Depends on fhfa_pkg for the field widths.
interface fhfa_out_if import fhfa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CELL_W-1:0]        cell_index;
  logic signed [HEAT_W-1:0] heat_value;

  modport source(output valid, cell_index, heat_value, input ready);
  modport sink(input valid, cell_index, heat_value, output ready);
endinterface

@@ hw/rtl/fhfa_div.sv @@
// Restoring divider that forms the volume weight (vol_a << 16) / (vol_a + vol_b).
// One quotient bit per cycle. Depends on fhfa_pkg.
module fhfa_div import fhfa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [16:0] quotient
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [47:0] dvd_r, dvd_nxt;
  logic [47:0] quo_r, quo_nxt;
  logic [33:0] trial;
  logic        fits;

  // Shift in the next dividend bit and try to subtract.
  assign trial = {rem_r, dvd_r[47]};
  assign fits  = trial >= {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? 33'(trial - {1'b0, divisor}) : trial[32:0];
      dvd_nxt = {dvd_r[46:0], 1'b0};
      quo_nxt = {quo_r[46:0], fits};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd47) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r[16:0];

endmodule

@@ hw/rtl/fhfa_flux.sv @@
// Flux datapath: weights, conductivity-gradient products, normal dot product
// and area scaling with saturation, one item at a time. Uses fhfa_div.
module fhfa_flux import fhfa_pkg::*; #(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  item_t                       item,
  output flux_stat_t                  stat,
  output logic signed [ACC_WIDTH-1:0] value
);

  localparam logic [3:0] F_IDLE = 4'd0;
  localparam logic [3:0] F_DIV  = 4'd1;
  localparam logic [3:0] F_KGA  = 4'd2;
  localparam logic [3:0] F_KGB  = 4'd3;
  localparam logic [3:0] F_WA   = 4'd4;
  localparam logic [3:0] F_WB   = 4'd5;
  localparam logic [3:0] F_AVG  = 4'd6;
  localparam logic [3:0] F_NP   = 4'd7;
  localparam logic [3:0] F_ACC  = 4'd8;
  localparam logic [3:0] F_MAG  = 4'd9;
  localparam logic [3:0] F_PL   = 4'd10;
  localparam logic [3:0] F_PH   = 4'd11;
  localparam logic [3:0] F_FIN  = 4'd12;

  localparam logic [71:0] LIM_POS = (72'd1 << (ACC_WIDTH - 1)) - 72'd1;
  localparam logic [71:0] LIM_NEG = 72'd1 << (ACC_WIDTH - 1);

  logic [3:0]  state_r, state_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        done_r, done_nxt;
  logic        skip_r, skip_nxt;
  logic [16:0] wa_r, wa_nxt;
  logic [16:0] wb_r, wb_nxt;
  logic signed [43:0] kga_r, kga_nxt;
  logic signed [43:0] kgb_r, kgb_nxt;
  logic signed [61:0] pa_r, pa_nxt;
  logic signed [61:0] pb_r, pb_nxt;
  logic signed [46:0] avg_r, avg_nxt;
  logic signed [67:0] np_r, np_nxt;
  logic signed [55:0] dot_r, dot_nxt;
  logic [55:0] mag_r, mag_nxt;
  logic        neg_r, neg_nxt;
  logic [59:0] pl_r, pl_nxt;
  logic [59:0] ph_r, ph_nxt;
  logic signed [ACC_WIDTH-1:0] value_r, value_nxt;

  logic        div_start;
  logic        div_done;
  logic [16:0] div_q;
  logic [32:0] vsum;

  logic [31:0]              cond_sel;
  logic signed [COMP_W-1:0] grad_sel;
  logic signed [53:0]       kg_prod;
  logic signed [53:0]       kg_rnd;
  logic [16:0]              w_sel;
  logic signed [43:0]       kg_sel;
  logic signed [61:0]       w_prod;
  logic signed [62:0]       avg_sum;
  logic signed [62:0]       avg_rnd;
  logic signed [67:0]       np_prod;
  logic signed [67:0]       np_rnd;
  logic [87:0]              area_prod;
  logic [71:0]              scaled;
  logic [71:0]              lim;
  logic [71:0]              clamped;
  logic [ACC_WIDTH-1:0]     mag_out;

  assign vsum = {1'b0, item.vol_a} + {1'b0, item.vol_b};

  fhfa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({item.vol_a, 16'd0}),
    .divisor  (vsum),
    .done     (div_done),
    .quotient (div_q)
  );

  // Conductivity times gradient component, truncated toward zero by 2^10.
  assign cond_sel = (state_r == F_KGB) ? item.cond_b : item.cond_a;
  assign grad_sel = pick_comp((state_r == F_KGB) ? item.grad_b_packed : item.grad_a_packed,
                              idx_r);
  assign kg_prod  = $signed({1'b0, cond_sel}) * grad_sel;
  assign kg_rnd   = kg_prod + (kg_prod[53] ? 54'sd1023 : 54'sd0);

  // Volume weight times the conductivity-gradient term.
  assign w_sel  = (state_r == F_WB) ? wb_r : wa_r;
  assign kg_sel = (state_r == F_WB) ? kgb_r : kga_r;
  assign w_prod = $signed({1'b0, w_sel}) * kg_sel;

  // Weighted average, truncated toward zero by 2^16.
  assign avg_sum = {pa_r[61], pa_r} + {pb_r[61], pb_r};
  assign avg_rnd = avg_sum + (avg_sum[62] ? 63'sd65535 : 63'sd0);

  // Product with the normal component, truncated toward zero by 2^15.
  assign np_prod = avg_r * pick_comp(item.normal_packed, idx_r);
  assign np_rnd  = np_r + (np_r[67] ? 68'sd32767 : 68'sd0);

  // Area scaling from two partial products, then saturation.
  assign area_prod = {ph_r, 28'd0} + {28'd0, pl_r};
  assign scaled    = area_prod[87:16];
  assign lim       = neg_r ? LIM_NEG : LIM_POS;
  assign clamped   = (scaled > lim) ? lim : scaled;
  assign mag_out   = clamped[ACC_WIDTH-1:0];

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    done_nxt  = 1'b0;
    skip_nxt  = skip_r;
    wa_nxt    = wa_r;
    wb_nxt    = wb_r;
    kga_nxt   = kga_r;
    kgb_nxt   = kgb_r;
    pa_nxt    = pa_r;
    pb_nxt    = pb_r;
    avg_nxt   = avg_r;
    np_nxt    = np_r;
    dot_nxt   = dot_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    pl_nxt    = pl_r;
    ph_nxt    = ph_r;
    value_nxt = value_r;
    div_start = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (start) begin
          idx_nxt  = '0;
          dot_nxt  = '0;
          skip_nxt = 1'b0;
          if (item.kind == KIND_INTERIOR) begin
            if (vsum == '0) begin
              skip_nxt  = 1'b1;
              value_nxt = '0;
              done_nxt  = 1'b1;
            end else begin
              div_start = 1'b1;
              state_nxt = F_DIV;
            end
          end else begin
            wa_nxt    = 17'd65536;
            wb_nxt    = '0;
            state_nxt = F_KGA;
          end
        end
      end
      F_DIV: begin
        if (div_done) begin
          wa_nxt    = div_q;
          wb_nxt    = 17'(17'd65536 - div_q);
          state_nxt = F_KGA;
        end
      end
      F_KGA: begin
        kga_nxt   = kg_rnd[53:10];
        state_nxt = F_KGB;
      end
      F_KGB: begin
        kgb_nxt   = kg_rnd[53:10];
        state_nxt = F_WA;
      end
      F_WA: begin
        pa_nxt    = w_prod;
        state_nxt = F_WB;
      end
      F_WB: begin
        pb_nxt    = w_prod;
        state_nxt = F_AVG;
      end
      F_AVG: begin
        avg_nxt   = avg_rnd[62:16];
        state_nxt = F_NP;
      end
      F_NP: begin
        np_nxt    = np_prod;
        state_nxt = F_ACC;
      end
      F_ACC: begin
        dot_nxt = dot_r + 56'($signed(np_rnd[67:15]));
        if (idx_r == 2'd2) begin
          state_nxt = F_MAG;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = F_KGA;
        end
      end
      F_MAG: begin
        mag_nxt   = dot_r[55] ? 56'(-dot_r) : 56'(dot_r);
        neg_nxt   = dot_r[55] ^ (item.kind == KIND_WALL);
        state_nxt = F_PL;
      end
      F_PL: begin
        pl_nxt    = mag_r[27:0] * item.face_area;
        state_nxt = F_PH;
      end
      F_PH: begin
        ph_nxt    = mag_r[55:28] * item.face_area;
        state_nxt = F_FIN;
      end
      F_FIN: begin
        value_nxt = neg_r ? $signed(-mag_out) : $signed(mag_out);
        done_nxt  = 1'b1;
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      done_r  <= 1'b0;
      skip_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      skip_r  <= skip_nxt;
      idx_r   <= idx_nxt;
    end
    wa_r    <= wa_nxt;
    wb_r    <= wb_nxt;
    kga_r   <= kga_nxt;
    kgb_r   <= kgb_nxt;
    pa_r    <= pa_nxt;
    pb_r    <= pb_nxt;
    avg_r   <= avg_nxt;
    np_r    <= np_nxt;
    dot_r   <= dot_nxt;
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    pl_r    <= pl_nxt;
    ph_r    <= ph_nxt;
    value_r <= value_nxt;
  end

  assign stat.done = done_r;
  assign stat.skip = skip_r;
  assign value     = value_r;

endmodule

@@ hw/rtl/fhfa_acc_mem.sv @@
// Per-cell accumulator memory with a registered read and a clearing
// pass after reset. Depends on fhfa_pkg.
module fhfa_acc_mem import fhfa_pkg::*; #(
  parameter int CELL_COUNT = CELL_COUNT_DEF,
  parameter int ACC_WIDTH  = ACC_WIDTH_DEF,
  localparam int ADDR_W    = $clog2(CELL_COUNT)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mem_ctl_t                    ctl,
  input  logic [ADDR_W-1:0]           rd_addr,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic signed [ACC_WIDTH-1:0] wr_data,
  output logic signed [ACC_WIDTH-1:0] rd_data,
  output logic                        clearing
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);

  logic signed [ACC_WIDTH-1:0] mem [CELL_COUNT];
  logic signed [ACC_WIDTH-1:0] rd_data_r;
  logic                        clr_busy_r, clr_busy_nxt;
  logic [ADDR_W-1:0]           clr_addr_r, clr_addr_nxt;

  // Clearing pass walks every entry once after reset.
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == LAST_ADDR) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Write port: clearing pass first, then accumulator updates.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (ctl.wr) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_busy_r;

endmodule

@@ hw/rtl/face_heat_flux_accumulate.sv @@
// Face heat flux accumulator. Each input beat is one mesh face or a read of one
// cell; each gives exactly one result beat. Items are handled one at a time; the
// result of an interior face waits on the weight divider and the seven-step
// product sequence run once per vector component. An other boundary face and
// an interior face with both volumes zero give a zero result and update no cell.
// Updates are a read-modify-write of the accumulator memory, cell A first and
// then, for an interior face, cell B, so a face with the same cell on both sides
// sees its own first update. After reset a clearing pass writes CELL_COUNT zero
// entries, one per cycle, and no input beat is taken until it ends. A finished
// result waits in an output register while the next beat is already taken. Cell
// indexes at or beyond CELL_COUNT are not updated and read as zero. Depends on
// fhfa_pkg, the two channel interfaces, fhfa_flux and fhfa_acc_mem.
module face_heat_flux_accumulate import fhfa_pkg::*; #(
  parameter int CELL_COUNT = CELL_COUNT_DEF,
  parameter int ACC_WIDTH  = ACC_WIDTH_DEF
) (
  input logic            clk,
  input logic            rst_n,
  fhfa_in_if.sink        in_beat,
  fhfa_out_if.source     out_beat
);

  localparam int ADDR_W = $clog2(CELL_COUNT);

  localparam logic [2:0] T_IDLE   = 3'd0;
  localparam logic [2:0] T_RD     = 3'd1;
  localparam logic [2:0] T_FLUX   = 3'd2;
  localparam logic [2:0] T_A_WAIT = 3'd3;
  localparam logic [2:0] T_B_RD   = 3'd4;
  localparam logic [2:0] T_B_WAIT = 3'd5;
  localparam logic [2:0] T_OUT    = 3'd6;
  localparam logic [2:0] T_FSTART = 3'd7;

  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic [2:0] state_r, state_nxt;
  item_t      item_r, item_nxt;
  item_t      in_item;
  logic signed [ACC_WIDTH-1:0] value_r, value_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0]           out_cell_r, out_cell_nxt;
  logic signed [HEAT_W-1:0]    out_heat_r, out_heat_nxt;

  logic                        flux_start;
  flux_stat_t                  flux_stat;
  logic signed [ACC_WIDTH-1:0] flux_value;

  mem_ctl_t                    mem_ctl;
  logic [ADDR_W-1:0]           rd_addr;
  logic [ADDR_W-1:0]           wr_addr;
  logic signed [ACC_WIDTH-1:0] wr_data;
  logic signed [ACC_WIDTH-1:0] rd_data;
  logic                        clearing;

  logic                        in_fire;
  logic                        a_ok;
  logic                        b_ok;
  logic                        in_a_ok;
  logic signed [ACC_WIDTH:0]   sum_ext;
  logic signed [ACC_WIDTH:0]   dif_ext;
  logic signed [ACC_WIDTH-1:0] sum_sat;
  logic signed [ACC_WIDTH-1:0] dif_sat;

  // Gather the input beat into one item.
  assign in_item.kind          = in_beat.kind;
  assign in_item.cell_a        = in_beat.cell_a;
  assign in_item.cell_b        = in_beat.cell_b;
  assign in_item.normal_packed = in_beat.normal_packed;
  assign in_item.face_area     = in_beat.face_area;
  assign in_item.grad_a_packed = in_beat.grad_a_packed;
  assign in_item.grad_b_packed = in_beat.grad_b_packed;
  assign in_item.cond_a        = in_beat.cond_a;
  assign in_item.cond_b        = in_beat.cond_b;
  assign in_item.vol_a         = in_beat.vol_a;
  assign in_item.vol_b         = in_beat.vol_b;

  assign in_beat.ready = (state_r == T_IDLE) && !clearing;
  assign in_fire       = in_beat.valid && in_beat.ready;

  // Cell range checks.
  assign a_ok    = 32'(item_r.cell_a) < CELL_COUNT;
  assign b_ok    = 32'(item_r.cell_b) < CELL_COUNT;
  assign in_a_ok = 32'(in_beat.cell_a) < CELL_COUNT;

  // Saturating add to cell A and subtract from cell B.
  assign sum_ext = {rd_data[ACC_WIDTH-1], rd_data} + {value_r[ACC_WIDTH-1], value_r};
  assign dif_ext = {rd_data[ACC_WIDTH-1], rd_data} - {value_r[ACC_WIDTH-1], value_r};
  assign sum_sat = (sum_ext[ACC_WIDTH] != sum_ext[ACC_WIDTH-1]) ?
                   (sum_ext[ACC_WIDTH] ? ACC_MIN : ACC_MAX) : sum_ext[ACC_WIDTH-1:0];
  assign dif_sat = (dif_ext[ACC_WIDTH] != dif_ext[ACC_WIDTH-1]) ?
                   (dif_ext[ACC_WIDTH] ? ACC_MIN : ACC_MAX) : dif_ext[ACC_WIDTH-1:0];

  fhfa_flux #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_flux (
    .clk   (clk),
    .rst_n (rst_n),
    .start (flux_start),
    .item  (item_r),
    .stat  (flux_stat),
    .value (flux_value)
  );

  fhfa_acc_mem #(
    .CELL_COUNT (CELL_COUNT),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mem_ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  // Item sequencer: compute, read-modify-write the cells, hand off the result.
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    value_nxt     = value_r;
    flux_start    = 1'b0;
    mem_ctl.rd    = 1'b0;
    mem_ctl.wr    = 1'b0;
    rd_addr       = ADDR_W'(item_r.cell_a);
    wr_addr       = ADDR_W'(item_r.cell_a);
    wr_data       = sum_sat;
    out_valid_nxt = out_valid_r && !out_beat.ready;
    out_cell_nxt  = out_cell_r;
    out_heat_nxt  = out_heat_r;
    unique case (state_r)
      T_IDLE: begin
        if (in_fire) begin
          item_nxt = in_item;
          unique case (in_beat.kind)
            KIND_READ: begin
              mem_ctl.rd = in_a_ok;
              rd_addr    = ADDR_W'(in_beat.cell_a);
              state_nxt  = T_RD;
            end
            KIND_OTHER: begin
              value_nxt = '0;
              state_nxt = T_OUT;
            end
            default: begin
              state_nxt = T_FSTART;
            end
          endcase
        end
      end
      T_RD: begin
        value_nxt = a_ok ? rd_data : '0;
        state_nxt = T_OUT;
      end
      T_FSTART: begin
        // The captured item is stable now; start the flux unit.
        flux_start = 1'b1;
        state_nxt  = T_FLUX;
      end
      T_FLUX: begin
        if (flux_stat.done) begin
          value_nxt = flux_value;
          if (flux_stat.skip) begin
            state_nxt = T_OUT;
          end else begin
            mem_ctl.rd = 1'b1;
            state_nxt  = T_A_WAIT;
          end
        end
      end
      T_A_WAIT: begin
        mem_ctl.wr = a_ok;
        state_nxt  = (item_r.kind == KIND_INTERIOR) ? T_B_RD : T_OUT;
      end
      T_B_RD: begin
        mem_ctl.rd = 1'b1;
        rd_addr    = ADDR_W'(item_r.cell_b);
        state_nxt  = T_B_WAIT;
      end
      T_B_WAIT: begin
        mem_ctl.wr = b_ok;
        wr_addr    = ADDR_W'(item_r.cell_b);
        wr_data    = dif_sat;
        state_nxt  = T_OUT;
      end
      T_OUT: begin
        if (!out_valid_r || out_beat.ready) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt  = item_r.cell_a;
          out_heat_nxt  = HEAT_W'(value_r);
          state_nxt     = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    value_r    <= value_nxt;
    out_cell_r <= out_cell_nxt;
    out_heat_r <= out_heat_nxt;
  end

  assign out_beat.valid      = out_valid_r;
  assign out_beat.cell_index = out_cell_r;
  assign out_beat.heat_value = out_heat_r;

endmodule
